[hdl/i2cs_pkg.sv]
`default_nettype none
package i2cs_pkg;

  // Buffer geometry. The buffer is split into an even and an odd bank.
  localparam int BUF_BYTES  = 16;
  localparam int BANK_DEPTH = BUF_BYTES / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // Length fields, byte counter and buffer positions.
  localparam int LEN_W = 5;
  // Wide enough to hold a position plus two.
  localparam int POS_W = LEN_W + 1;

  // CRC-8 polynomial and seed, and the reset device address.
  localparam logic [7:0] CRC_POLY       = 8'h31;
  localparam logic [7:0] CRC_INIT       = 8'hFF;
  localparam logic [6:0] DEV_ADDR_RESET = 7'h62;

  // Register port.
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam int DEV_AW   = 7;
  localparam logic REG_DEVICE_ADDRESS = 1'b0;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_EVENT = 2'd2,
    KIND_CHECK = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    EV_START_SENT   = 3'd0,
    EV_RESTART_SENT = 3'd1,
    EV_ADDRW_ACK    = 3'd2,
    EV_DATAW_ACK    = 3'd3,
    EV_ADDRR_ACK    = 3'd4,
    EV_BYTE_ACKED   = 3'd5,
    EV_BYTE_NACKED  = 3'd6,
    EV_OTHER        = 3'd7
  } bus_event_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_SEND    = 3'd2,
    ACT_RESTART = 3'd3,
    ACT_RX_ACK  = 3'd4,
    ACT_RX_NACK = 3'd5,
    ACT_STOP    = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PENDING = 2'd1,
    ST_ERROR   = 2'd2
  } status_t;

  // Request to the byte buffer: one write and one read base position.
  typedef struct packed {
    logic             wr_en;
    logic [LEN_W-1:0] wr_pos;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [LEN_W-1:0] rd_pos;
  } buf_req_t;

  // Bytes at the read base position and the two after it; zero past the end.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } buf_rsp_t;

  // One byte of the CRC-8 (MSB first, no reflection).
  function automatic logic [7:0] crc8_step(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    crc = crc_in ^ data;
    for (int k = 0; k < 8; k++) begin
      if (crc[7]) begin
        crc = {crc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

[hdl/i2cs_if.sv]
`default_nettype none
// Request channel: one item per transaction.
interface i2cs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] index;
  logic [7:0] data_byte;
  logic [4:0] write_len;
  logic [4:0] read_len;
  logic [2:0] bus_event;

  modport source (output valid, kind, index, data_byte, write_len, read_len, bus_event,
                  input ready);
  modport sink (input valid, kind, index, data_byte, write_len, read_len, bus_event,
                output ready);
endinterface

// Response channel: one result per transaction.
interface i2cs_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  tx_byte;
  logic [1:0]  status;
  logic [15:0] word_value;
  logic        crc_ok;

  modport source (output valid, action, tx_byte, status, word_value, crc_ok, input ready);
  modport sink (input valid, action, tx_byte, status, word_value, crc_ok, output ready);
endinterface
`default_nettype wire

[hdl/i2cs_buffer.sv]
`default_nettype none
// Byte buffer held in two banks (even and odd positions). Each bank has one
// write port and two read ports, so three consecutive bytes come out in one
// read. Read data is registered.
module i2cs_buffer (
  input  wire logic               clk,
  input  wire i2cs_pkg::buf_req_t req,
  output i2cs_pkg::buf_rsp_t      rsp
);

  logic [7:0] even_mem [i2cs_pkg::BANK_DEPTH];
  logic [7:0] odd_mem  [i2cs_pkg::BANK_DEPTH];

  logic [i2cs_pkg::LEN_W-2:0]   half;
  logic [i2cs_pkg::LEN_W-1:0]   half_inc;
  logic [i2cs_pkg::BANK_AW-1:0] addr_lo;
  logic [i2cs_pkg::BANK_AW-1:0] addr_hi;
  logic [i2cs_pkg::BANK_AW-1:0] wr_addr;
  logic [i2cs_pkg::POS_W-1:0]   pos_ext;
  logic [2:0]                   in_buf;

  logic [7:0] even_lo;
  logic [7:0] even_hi;
  logic [7:0] odd_lo;
  logic [7:0] odd_hi;
  logic       odd_base;
  logic [2:0] in_buf_q;

  // Bank addresses for the base position and the pair after it.
  always_comb begin
    half     = req.rd_pos[i2cs_pkg::LEN_W-1:1];
    half_inc = {1'b0, half} + i2cs_pkg::LEN_W'(1);
    addr_lo  = half[i2cs_pkg::BANK_AW-1:0];
    addr_hi  = half_inc[i2cs_pkg::BANK_AW-1:0];
    wr_addr  = req.wr_pos[i2cs_pkg::BANK_AW:1];
    pos_ext  = {1'b0, req.rd_pos};
    for (int k = 0; k < 3; k++) begin
      in_buf[k] = (pos_ext + i2cs_pkg::POS_W'(k)) < i2cs_pkg::POS_W'(i2cs_pkg::BUF_BYTES);
    end
  end

  // Memory write and registered reads.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      if (req.wr_pos[0]) begin
        odd_mem[wr_addr] <= req.wr_data;
      end else begin
        even_mem[wr_addr] <= req.wr_data;
      end
    end
    if (req.rd_en) begin
      even_lo  <= even_mem[addr_lo];
      even_hi  <= even_mem[addr_hi];
      odd_lo   <= odd_mem[addr_lo];
      odd_hi   <= odd_mem[addr_hi];
      odd_base <= req.rd_pos[0];
      in_buf_q <= in_buf;
    end
  end

  // Put the bank outputs back in buffer order; positions past the end read zero.
  always_comb begin
    rsp.b0 = in_buf_q[0] ? (odd_base ? odd_lo  : even_lo) : 8'h00;
    rsp.b1 = in_buf_q[1] ? (odd_base ? even_hi : odd_lo)  : 8'h00;
    rsp.b2 = in_buf_q[2] ? (odd_base ? odd_hi  : even_hi) : 8'h00;
  end

endmodule
`default_nettype wire

[hdl/i2c_write_read_transaction_sequencer.sv]
`default_nettype none
// Channel  Direction  Handshake      Contents
// req      in         valid/ready    kind, index, data_byte, write_len, read_len, bus_event
// rsp      out        valid/ready    action, tx_byte, status, word_value, crc_ok
// apb      in         psel/penable   device_address at byte address 0
//
// One transaction is taken per cycle while rsp is not held; each result passes
// the registered buffer read and the two CRC stages before it appears.
// When rsp is held, the whole pipeline holds and req.ready drops.
// Reset clears the control registers and the pipeline valid bits; device_address
// returns to 0x62. Buffer contents are not cleared.
module i2c_write_read_transaction_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [i2cs_pkg::APB_AW-1:0]   paddr,
  input  wire logic [i2cs_pkg::APB_DW-1:0]   pwdata,
  output logic      [i2cs_pkg::APB_DW-1:0]   prdata,
  output logic                               pready,
  i2cs_req_if.sink                           req,
  i2cs_rsp_if.source                         rsp
);

  // Control registers.
  logic [i2cs_pkg::DEV_AW-1:0] device_address;
  logic [i2cs_pkg::LEN_W-1:0]  byte_counter, byte_counter_next;
  logic [i2cs_pkg::LEN_W-1:0]  write_request, write_request_next;
  logic [i2cs_pkg::LEN_W-1:0]  read_request, read_request_next;
  i2cs_pkg::status_t           link_status, link_status_next;

  // Request decode.
  i2cs_pkg::kind_t      kind;
  i2cs_pkg::bus_event_t ev;
  i2cs_pkg::action_t    act;
  logic [7:0]           tx_imm;
  logic                 tx_from_buf;
  logic                 idx_in_buf;
  logic                 cnt_in_buf;
  logic [i2cs_pkg::POS_W-1:0] cnt_ext;
  logic                 advance;
  logic                 accept;

  i2cs_pkg::buf_req_t   buf_req;
  i2cs_pkg::buf_rsp_t   buf_rsp;

  // Stage 1: buffer read in flight.
  logic                 s1_valid;
  i2cs_pkg::action_t    s1_action;
  logic [7:0]           s1_tx_imm;
  logic                 s1_tx_buf;
  i2cs_pkg::status_t    s1_status;
  logic                 s1_check;

  // Stage 2: first CRC byte done.
  logic                 s2_valid;
  i2cs_pkg::action_t    s2_action;
  logic [7:0]           s2_tx;
  i2cs_pkg::status_t    s2_status;
  logic                 s2_check;
  logic [15:0]          s2_word;
  logic [7:0]           s2_crc;
  logic [7:0]           s2_b2;

  // Output register.
  logic                 out_valid;
  i2cs_pkg::action_t    out_action;
  logic [7:0]           out_tx;
  i2cs_pkg::status_t    out_status;
  logic [15:0]          out_word;
  logic                 out_crc_ok;

  // Register port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == i2cs_pkg::REG_DEVICE_ADDRESS)
                ? i2cs_pkg::APB_DW'(device_address) : '0;

  // Pipeline moves whenever the output register is free or being taken.
  assign advance   = !out_valid || rsp.ready;
  assign req.ready = advance;
  assign accept    = req.valid && advance;

  assign kind       = i2cs_pkg::kind_t'(req.kind);
  assign ev         = i2cs_pkg::bus_event_t'(req.bus_event);
  assign cnt_ext    = {1'b0, byte_counter};
  assign idx_in_buf = {2'b00, req.index} < i2cs_pkg::POS_W'(i2cs_pkg::BUF_BYTES);
  assign cnt_in_buf = cnt_ext < i2cs_pkg::POS_W'(i2cs_pkg::BUF_BYTES);

  // Next bus action and control state for the incoming transaction.
  always_comb begin
    byte_counter_next  = byte_counter;
    write_request_next = write_request;
    read_request_next  = read_request;
    link_status_next   = link_status;
    act                = i2cs_pkg::ACT_NONE;
    tx_imm             = 8'h00;
    tx_from_buf        = 1'b0;
    buf_req.wr_en      = 1'b0;
    buf_req.wr_pos     = byte_counter;
    buf_req.wr_data    = req.data_byte;
    buf_req.rd_en      = advance;
    buf_req.rd_pos     = byte_counter;

    unique case (kind)
      i2cs_pkg::KIND_LOAD: begin
        buf_req.wr_pos = {1'b0, req.index};
        if (idx_in_buf) begin
          buf_req.wr_en = accept;
        end else begin
          link_status_next = i2cs_pkg::ST_ERROR;
        end
      end
      i2cs_pkg::KIND_START: begin
        write_request_next = req.write_len;
        read_request_next  = req.read_len;
        byte_counter_next  = '0;
        link_status_next   = i2cs_pkg::ST_PENDING;
        act                = i2cs_pkg::ACT_START;
      end
      i2cs_pkg::KIND_EVENT: begin
        unique case (ev) inside
          i2cs_pkg::EV_START_SENT: begin
            act    = i2cs_pkg::ACT_SEND;
            tx_imm = {device_address, 1'b0};
          end
          i2cs_pkg::EV_RESTART_SENT: begin
            act    = i2cs_pkg::ACT_SEND;
            tx_imm = {device_address, 1'b1};
          end
          i2cs_pkg::EV_ADDRW_ACK, i2cs_pkg::EV_DATAW_ACK: begin
            if (byte_counter < write_request) begin
              if (!cnt_in_buf) begin
                byte_counter_next = '0;
                link_status_next  = i2cs_pkg::ST_ERROR;
                act               = i2cs_pkg::ACT_STOP;
              end else begin
                act               = i2cs_pkg::ACT_SEND;
                tx_from_buf       = 1'b1;
                byte_counter_next = byte_counter + i2cs_pkg::LEN_W'(1);
              end
            end else if (read_request != '0) begin
              byte_counter_next = '0;
              act               = i2cs_pkg::ACT_RESTART;
            end else begin
              act              = i2cs_pkg::ACT_STOP;
              link_status_next = i2cs_pkg::ST_IDLE;
            end
          end
          i2cs_pkg::EV_ADDRR_ACK: begin
            act = (read_request <= i2cs_pkg::LEN_W'(1)) ? i2cs_pkg::ACT_RX_NACK
                                                          : i2cs_pkg::ACT_RX_ACK;
          end
          i2cs_pkg::EV_BYTE_ACKED: begin
            if (byte_counter < read_request && cnt_in_buf) begin
              buf_req.wr_en     = accept;
              byte_counter_next = byte_counter + i2cs_pkg::LEN_W'(1);
              // Ask for one more byte unless the next one is the last.
              act = ((cnt_ext + i2cs_pkg::POS_W'(2)) != {1'b0, read_request})
                  ? i2cs_pkg::ACT_RX_ACK : i2cs_pkg::ACT_RX_NACK;
            end else begin
              byte_counter_next = '0;
              link_status_next  = i2cs_pkg::ST_ERROR;
              act               = i2cs_pkg::ACT_STOP;
            end
          end
          i2cs_pkg::EV_BYTE_NACKED: begin
            if (cnt_in_buf) begin
              buf_req.wr_en    = accept;
              link_status_next = ((cnt_ext + i2cs_pkg::POS_W'(1)) == {1'b0, read_request})
                               ? i2cs_pkg::ST_IDLE : i2cs_pkg::ST_ERROR;
            end else begin
              link_status_next = i2cs_pkg::ST_ERROR;
            end
            byte_counter_next = '0;
            act               = i2cs_pkg::ACT_STOP;
          end
          default: begin
            byte_counter_next = '0;
            link_status_next  = i2cs_pkg::ST_ERROR;
            act               = i2cs_pkg::ACT_STOP;
          end
        endcase
      end
      i2cs_pkg::KIND_CHECK: begin
        buf_req.rd_pos = {1'b0, req.index};
      end
      default: begin
        act = i2cs_pkg::ACT_NONE;
      end
    endcase
  end

  i2cs_buffer u_buffer (
    .clk (clk),
    .req (buf_req),
    .rsp (buf_rsp)
  );

  // Register port write.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= i2cs_pkg::DEV_ADDR_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == i2cs_pkg::REG_DEVICE_ADDRESS) begin
      device_address <= pwdata[i2cs_pkg::DEV_AW-1:0];
    end
  end

  // Control state update on each accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_counter  <= '0;
      write_request <= '0;
      read_request  <= '0;
      link_status   <= i2cs_pkg::ST_IDLE;
    end else if (accept) begin
      byte_counter  <= byte_counter_next;
      write_request <= write_request_next;
      read_request  <= read_request_next;
      link_status   <= link_status_next;
    end
  end

  // Pipeline valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= req.valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // Pipeline payload: tx byte select, then the two CRC bytes.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_action  <= act;
      s1_tx_imm  <= tx_imm;
      s1_tx_buf  <= tx_from_buf;
      s1_status  <= link_status_next;
      s1_check   <= kind == i2cs_pkg::KIND_CHECK;

      s2_action  <= s1_action;
      s2_tx      <= s1_tx_buf ? buf_rsp.b0 : s1_tx_imm;
      s2_status  <= s1_status;
      s2_check   <= s1_check;
      s2_word    <= s1_check ? {buf_rsp.b0, buf_rsp.b1} : 16'h0000;
      s2_crc     <= i2cs_pkg::crc8_step(i2cs_pkg::CRC_INIT, buf_rsp.b0);
      s2_b2      <= buf_rsp.b2;

      out_action <= s2_action;
      out_tx     <= s2_tx;
      out_status <= s2_status;
      out_word   <= s2_word;
      out_crc_ok <= s2_check && (i2cs_pkg::crc8_step(s2_crc, s2_word[7:0]) == s2_b2);
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.action     = out_action;
  assign rsp.tx_byte    = out_tx;
  assign rsp.status     = out_status;
  assign rsp.word_value = out_word;
  assign rsp.crc_ok     = out_crc_ok;

  // A start always leaves the link pending.
  a_start_pending: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == i2cs_pkg::KIND_START) |=> link_status == i2cs_pkg::ST_PENDING)
    else $error("start did not leave the link pending");

  // An in-range buffer load does not touch the link status.
  a_load_keeps_status: assert property (@(posedge clk) disable iff (rst)
    (accept && kind == i2cs_pkg::KIND_LOAD && idx_in_buf) |=> $stable(link_status))
    else $error("in-range load changed the link status");

  // While the output is held, the stage behind it holds too.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!advance) |=> ($stable(s2_valid) && $stable(s2_action) && $stable(s2_tx)))
    else $error("pipeline moved during a stall");

endmodule
`default_nettype wire
